### rtl/core/brb_pkg.sv
// shared types and constants of the byte ring buffer
package brb_pkg;

	// default store depth and the largest block of one write, read or peek
	localparam int DEPTH_DEF = 4096;
	localparam int MAX_BLOCK = 8;

	// field widths of the request and result words
	localparam int KIND_W   = 3;
	localparam int LEN_W    = 13;
	localparam int DATA_W   = 64;
	localparam int BYTES    = 8;
	localparam int LANE_W   = 3;
	localparam int HELD_W   = 12;
	localparam int STATUS_W = 2;

	// ring size after reset and the smallest usable ring
	localparam int SIZE_RESET = 4096;
	localparam int SIZE_MIN   = 2;

	// request kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE   = 3'd0,
		KIND_READ    = 3'd1,
		KIND_PEEK    = 3'd2,
		KIND_SKIP    = 3'd3,
		KIND_RECYCLE = 3'd4
	} kind_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE     = 2'd0,
		ST_NOSPACE  = 2'd1,
		ST_TOOLONG  = 2'd2
	} status_t;

	// byte store access strobes
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

### rtl/core/brb_store.sv
// byte-wide single-port store: a registered read and a write on one shared address
module brb_store #(
	parameter int DEPTH = brb_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  brb_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]     addr,
	input  logic [7:0]        wdata,
	output logic [7:0]        rdata
);

	logic [7:0] mem [DEPTH];

	// write and read share the address; the sequencer never strobes both
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata <= mem[addr];
		end
	end

endmodule

### rtl/core/brb_ctrl.sv
// request sequencer: pointer bookkeeping, byte moves and result register
module brb_ctrl #(
	parameter int DEPTH = brb_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [brb_pkg::LEN_W-1:0]    cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [brb_pkg::KIND_W-1:0]   kind,
	input  logic [brb_pkg::LEN_W-1:0]    length,
	input  logic [brb_pkg::DATA_W-1:0]   write_bytes,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [brb_pkg::STATUS_W-1:0] status,
	output logic [brb_pkg::LEN_W-1:0]    done_length,
	output logic [brb_pkg::DATA_W-1:0]   read_bytes,
	output logic [brb_pkg::HELD_W-1:0]   held_count,
	output brb_pkg::mem_ctl_t            mem_ctl,
	output logic [AW-1:0]                mem_addr,
	output logic [7:0]                   mem_wdata,
	input  logic [7:0]                   mem_rdata
);

	localparam int SW = $clog2(DEPTH + 1);
	localparam int CW = (SW > brb_pkg::LEN_W) ? SW : brb_pkg::LEN_W;
	localparam int SIZE_RST = (DEPTH < brb_pkg::SIZE_RESET) ? DEPTH : brb_pkg::SIZE_RESET;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EVAL  = 6'b000010,
		S_CHECK = 6'b000100,
		S_MOVE  = 6'b001000,
		S_DRAIN = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t                                      state_q;
	logic [SW-1:0]                               size_q;
	logic [AW-1:0]                               head_q;
	logic [AW-1:0]                               tail_q;
	logic [AW-1:0]                               ptr_q;
	logic [brb_pkg::LANE_W-1:0]                  cnt_q;
	brb_pkg::kind_t                              kind_q;
	logic [brb_pkg::LEN_W-1:0]                   len_q;
	logic [brb_pkg::BYTES-1:0][7:0]              wdata_q;
	logic [SW-1:0]                               held_q;
	logic [SW-1:0]                               free_q;
	brb_pkg::status_t                            res_status_q;
	logic [brb_pkg::LEN_W-1:0]                   res_done_q;
	logic [SW-1:0]                               res_held_q;
	logic [brb_pkg::BYTES-1:0][7:0]              rdata_q;
	logic                                        rd_pend_s1;
	logic [brb_pkg::LANE_W-1:0]                  lane_s1;
	logic                                        out_valid_q;
	brb_pkg::status_t                            out_status_q;
	logic [brb_pkg::LEN_W-1:0]                   out_done_q;
	logic [brb_pkg::DATA_W-1:0]                  out_rdata_q;
	logic [brb_pkg::HELD_W-1:0]                  out_held_q;

	logic [CW-1:0]     cfg_v;
	logic [SW-1:0]     size_d;
	logic [SW-1:0]     held_d;
	logic [CW-1:0]     len_x;
	logic              is_rd;
	logic              too_long;
	logic              short_hold;
	logic              short_free;
	logic              move_req;
	logic [SW:0]       skip_sum;
	logic [AW-1:0]     skip_head;
	logic [SW:0]       ptr_inc;
	logic [AW-1:0]     ptr_nx;
	logic              last;
	logic              out_free;
	brb_pkg::status_t  res_status_d;
	logic [brb_pkg::LEN_W-1:0] res_done_d;
	logic [SW-1:0]     res_held_d;

	// clamp the configured ring size into two .. depth
	always_comb begin
		cfg_v = CW'(cfg_wr_data);
		if (cfg_v < CW'(brb_pkg::SIZE_MIN)) begin
			cfg_v = CW'(brb_pkg::SIZE_MIN);
		end
		if (cfg_v > CW'(DEPTH)) begin
			cfg_v = CW'(DEPTH);
		end
		size_d = SW'(cfg_v);
	end

	// held byte count from the two pointers
	always_comb begin
		if (tail_q >= head_q) begin
			held_d = SW'(tail_q) - SW'(head_q);
		end else begin
			held_d = SW'(tail_q) + size_q - SW'(head_q);
		end
	end

	// request checks against held and free bytes
	always_comb begin
		len_x      = CW'(len_q);
		is_rd      = kind_q inside {brb_pkg::KIND_READ, brb_pkg::KIND_PEEK};
		too_long   = (kind_q inside {brb_pkg::KIND_WRITE, brb_pkg::KIND_READ,
			brb_pkg::KIND_PEEK}) && (len_q > brb_pkg::LEN_W'(brb_pkg::MAX_BLOCK));
		short_hold = len_x > CW'(held_q);
		short_free = len_x > CW'(free_q);
		move_req   = !too_long && (len_q != '0) &&
			(((kind_q == brb_pkg::KIND_WRITE) && !short_free) || (is_rd && !short_hold));
		skip_sum   = (SW+1)'(head_q) + (SW+1)'(len_q);
		if (skip_sum >= (SW+1)'(size_q)) begin
			skip_sum = skip_sum - (SW+1)'(size_q);
		end
		skip_head  = AW'(skip_sum);
	end

	// result of the checked request
	always_comb begin
		res_status_d = brb_pkg::ST_DONE;
		res_done_d   = '0;
		res_held_d   = held_q;
		if (too_long) begin
			res_status_d = brb_pkg::ST_TOOLONG;
		end else begin
			case (kind_q)
				brb_pkg::KIND_WRITE: begin
					if (short_free) begin
						res_status_d = brb_pkg::ST_NOSPACE;
					end else begin
						res_done_d = len_q;
						res_held_d = held_q + SW'(len_q);
					end
				end
				brb_pkg::KIND_READ, brb_pkg::KIND_SKIP: begin
					if (short_hold) begin
						res_status_d = brb_pkg::ST_NOSPACE;
					end else begin
						res_done_d = len_q;
						res_held_d = held_q - SW'(len_q);
					end
				end
				brb_pkg::KIND_PEEK: begin
					if (short_hold) begin
						res_status_d = brb_pkg::ST_NOSPACE;
					end else begin
						res_done_d = len_q;
					end
				end
				brb_pkg::KIND_RECYCLE: begin
					res_held_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// ring step of the moving pointer
	always_comb begin
		ptr_inc = (SW+1)'(ptr_q) + (SW+1)'(1);
		ptr_nx  = (ptr_inc >= (SW+1)'(size_q)) ? '0 : AW'(ptr_inc);
		last    = (brb_pkg::LEN_W'(cnt_q) + brb_pkg::LEN_W'(1)) == len_q;
	end

	assign out_free = !out_valid_q || !out_stall;

	// sequencer, pointers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			size_q      <= SW'(SIZE_RST);
			head_q      <= '0;
			tail_q      <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= (state_q == S_MOVE) && is_rd;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				size_q <= size_d;
				head_q <= '0;
				tail_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (move_req) begin
						state_q <= S_MOVE;
					end else begin
						state_q <= S_DONE;
					end
					if (!too_long) begin
						case (kind_q)
							brb_pkg::KIND_SKIP: begin
								if (!short_hold) begin
									head_q <= skip_head;
								end
							end
							brb_pkg::KIND_RECYCLE: begin
								head_q <= '0;
								tail_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_MOVE: begin
					if (last) begin
						if (kind_q == brb_pkg::KIND_WRITE) begin
							tail_q  <= ptr_nx;
							state_q <= S_DONE;
						end else begin
							if (kind_q == brb_pkg::KIND_READ) begin
								head_q <= ptr_nx;
							end
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request, move and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			kind_q  <= brb_pkg::kind_t'(kind);
			len_q   <= length;
			wdata_q <= write_bytes;
		end
		if (state_q == S_EVAL) begin
			held_q <= held_d;
			free_q <= size_q - SW'(1) - held_d;
		end
		if (state_q == S_CHECK) begin
			ptr_q        <= (kind_q == brb_pkg::KIND_WRITE) ? tail_q : head_q;
			cnt_q        <= '0;
			rdata_q      <= '0;
			res_status_q <= res_status_d;
			res_done_q   <= res_done_d;
			res_held_q   <= res_held_d;
		end
		if (state_q == S_MOVE) begin
			ptr_q <= ptr_nx;
			cnt_q <= cnt_q + brb_pkg::LANE_W'(1);
		end
		lane_s1 <= cnt_q;
		// store read data arrives in the cycle after its address
		if (rd_pend_s1) begin
			rdata_q[lane_s1] <= mem_rdata;
		end
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_done_q   <= res_done_q;
			out_rdata_q  <= rdata_q;
			out_held_q   <= brb_pkg::HELD_W'(res_held_q);
		end
	end

	// byte store access
	always_comb begin
		mem_ctl.wr_en = (state_q == S_MOVE) && (kind_q == brb_pkg::KIND_WRITE);
		mem_ctl.rd_en = (state_q == S_MOVE) && is_rd;
		mem_addr      = ptr_q;
		mem_wdata     = wdata_q[cnt_q];
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign done_length = out_done_q;
	assign read_bytes  = out_rdata_q;
	assign held_count  = out_held_q;

endmodule

### rtl/core/byte_ring_buffer_block_fifo.sv
// Byte ring buffer with block requests. One request word is taken at a time:
// the block is busy from acceptance until its result is loaded into the output
// register, which frees the input side even while that result waits on a
// stalled consumer. Write, read and peek move one byte per cycle through the
// single-port byte store. Each request passes through evaluate and check, then
// the byte moves and, for read and peek, a drain of the store read, then done;
// skip, recycle, failing and zero-length requests go from check to done.
// Writing buffer_size empties the ring and must happen only while no request
// is in flight. The store is not cleared after reset; only held bytes are ever
// read.
module byte_ring_buffer_block_fifo #(
	parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [brb_pkg::LEN_W-1:0]    cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [brb_pkg::KIND_W-1:0]   kind,
	input  logic [brb_pkg::LEN_W-1:0]    length,
	input  logic [brb_pkg::DATA_W-1:0]   write_bytes,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [brb_pkg::STATUS_W-1:0] status,
	output logic [brb_pkg::LEN_W-1:0]    done_length,
	output logic [brb_pkg::DATA_W-1:0]   read_bytes,
	output logic [brb_pkg::HELD_W-1:0]   held_count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	brb_pkg::mem_ctl_t mem_ctl;
	logic [AW-1:0]     mem_addr;
	logic [7:0]        mem_wdata;
	logic [7:0]        mem_rdata;

	// request sequencer
	brb_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.length      (length),
		.write_bytes (write_bytes),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.done_length (done_length),
		.read_bytes  (read_bytes),
		.held_count  (held_count),
		.mem_ctl     (mem_ctl),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata),
		.mem_rdata   (mem_rdata)
	);

	// ring byte store
	brb_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

### rtl/core/brb_checker.sv
// port-level checks of the byte ring buffer, bound to the top level
module brb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [brb_pkg::STATUS_W-1:0] status,
	input logic [brb_pkg::LEN_W-1:0]    done_length,
	input logic [brb_pkg::DATA_W-1:0]   read_bytes
);

	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// one request at a time: busy right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while one is in flight");

	// only the three defined status codes appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == brb_pkg::ST_DONE || status == brb_pkg::ST_NOSPACE
			|| status == brb_pkg::ST_TOOLONG))
		else $error("undefined status code");

	// a failed request moves nothing and returns no data
	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != brb_pkg::ST_DONE |-> done_length == '0 && read_bytes == '0)
		else $error("failed request reports moved bytes");

endmodule

bind byte_ring_buffer_block_fifo brb_checker u_brb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.done_length (done_length),
	.read_bytes  (read_bytes)
);
